### hdl/virtual_interrupt_distributor_regs_core_assert.svh
// Assertion macros shared by the interrupt distributor register file.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef VIRTUAL_INTERRUPT_DISTRIBUTOR_REGS_CORE_ASSERT_SVH
`define VIRTUAL_INTERRUPT_DISTRIBUTOR_REGS_CORE_ASSERT_SVH

// Same-cycle implication.
`define VID_ASSERT_IMP(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication.
`define VID_ASSERT_NXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

### hdl/vid_pkg.sv
// Shared types and constants of the interrupt distributor register file.
// No dependencies.
package vid_pkg;

  localparam int SLOT_W = 12;
  localparam int QDEPTH = 2;
  localparam int CFG_WORDS = 64;
  localparam logic [31:0] IIDR_VALUE = 32'h0000_043B;

  typedef enum logic [3:0] {
    OP_BAD, OP_NOP, OP_CTLR, OP_CONST, OP_GROUP, OP_ENABLE,
    OP_PEND, OP_PRIO, OP_TARGET, OP_CFG
  } opc_t;

  typedef enum logic [1:0] {
    KIND_RESP = 2'd0,
    KIND_EN   = 2'd1,
    KIND_DIS  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE, S_RD, S_SCAN, S_RESP
  } st_t;

  typedef struct packed {
    opc_t              op;
    logic              wr;
    logic              set;
    logic [1:0]        guest;
    logic [SLOT_W-1:0] slot;
    logic [4:0]        eword;
    logic [31:0]       mask;
    logic [4:0]        sh;
    logic [31:0]       wdata;
  } vid_op_t;

endpackage

### hdl/vid_front.sv
// Front decoder: classifies one bus access into a queued operation.
// Depends on vid_pkg.
module vid_front import vid_pkg::*; #(
  parameter int NUM_GUESTS  = 4,
  parameter int IRQ_LINES   = 128,
  parameter int TABLE_WORDS = 128
) (
  input  logic        in_cmd,
  input  logic [1:0]  in_guest,
  input  logic [11:0] in_reg_offset,
  input  logic [31:0] in_wdata,
  input  logic [1:0]  in_access_size,
  output vid_op_t     op_o
);

  localparam int ENW = IRQ_LINES / 32;
  localparam logic [31:0] TYPER_VAL = 32'((IRQ_LINES / 32 - 1) % 32);

  logic [3:0]  region;
  logic [9:0]  w;
  logic        lane_ok;
  logic [31:0] lmask;
  logic [4:0]  lsh;

  assign region = in_reg_offset[11:8];
  assign w      = in_reg_offset[11:2];

  // lane mask and shift for sub-word access
  always_comb begin
    lane_ok = 1'b1;
    lmask   = 32'hFFFF_FFFF;
    lsh     = 5'd0;
    unique case (in_access_size)
      2'd2: begin
        lmask = 32'hFFFF_FFFF;
      end
      2'd1: begin
        lsh   = {in_reg_offset[1], 4'd0};
        lmask = 32'h0000_FFFF << lsh;
      end
      2'd0: begin
        lsh   = {in_reg_offset[1:0], 3'd0};
        lmask = 32'h0000_00FF << lsh;
      end
      default: begin
        lane_ok = 1'b0;
      end
    endcase
  end

  // classify by region
  always_comb begin
    op_o       = '0;
    op_o.op    = OP_BAD;
    op_o.wr    = in_cmd;
    op_o.guest = in_guest;
    op_o.mask  = lmask;
    op_o.sh    = lsh;
    op_o.wdata = in_wdata;
    op_o.eword = w[4:0];
    op_o.set   = ~w[5];
    if (32'(in_guest) < NUM_GUESTS) begin
      priority case (1'b1)
        region == 4'd0: begin
          if (w[5:0] == 6'd0) begin
            op_o.op = OP_CTLR;
          end else if (w[5:0] == 6'd1) begin
            if (!in_cmd) begin
              op_o.op    = OP_CONST;
              op_o.wdata = TYPER_VAL;
            end
          end else if (w[5:0] == 6'd2) begin
            if (!in_cmd) begin
              op_o.op    = OP_CONST;
              op_o.wdata = IIDR_VALUE;
            end
          end else if (w[5] && 32'(w[4:0]) < ENW) begin
            op_o.op   = OP_GROUP;
            op_o.slot = SLOT_W'(in_guest) * SLOT_W'(ENW) + SLOT_W'(w[4:0]);
          end
        end
        region == 4'd1: begin
          if (in_cmd && in_wdata == 32'd0) begin
            op_o.op = OP_NOP;
          end else if (lane_ok && 32'(w[4:0]) < ENW) begin
            op_o.op   = OP_ENABLE;
            op_o.slot = SLOT_W'(in_guest) * SLOT_W'(ENW) + SLOT_W'(w[4:0]);
          end
        end
        region == 4'd2: begin
          if (in_access_size == 2'd2 && 32'(w[4:0]) < ENW) begin
            op_o.op   = OP_PEND;
            op_o.slot = SLOT_W'(in_guest) * SLOT_W'(ENW) + SLOT_W'(w[4:0]);
          end
        end
        region[3:2] == 2'd1: begin
          if (32'(w[7:0]) < TABLE_WORDS) begin
            op_o.op   = OP_PRIO;
            op_o.slot = SLOT_W'(in_guest) * SLOT_W'(TABLE_WORDS) + SLOT_W'(w[7:0]);
          end
        end
        region[3:2] == 2'd2: begin
          if (32'(w[7:0]) < TABLE_WORDS && lane_ok) begin
            op_o.op   = (in_cmd && w[7:0] < 8'd8) ? OP_NOP : OP_TARGET;
            op_o.slot = SLOT_W'(in_guest) * SLOT_W'(TABLE_WORDS) + SLOT_W'(w[7:0]);
          end
        end
        region == 4'd12: begin
          op_o.op   = OP_CFG;
          op_o.slot = SLOT_W'(in_guest) * SLOT_W'(CFG_WORDS) + SLOT_W'(w[5:0]);
        end
        default: begin
          op_o.op = OP_BAD;
        end
      endcase
    end
  end

endmodule

### hdl/vid_queue.sv
// Two-word queue between the decoder and the execution unit.
// Depends on vid_pkg.
module vid_queue import vid_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  vid_op_t push_op,
  input  logic    pop,
  output vid_op_t head_op,
  output logic    empty,
  output logic    full
);

  vid_op_t    ent_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty   = (cnt_r == 2'd0);
  assign full    = (cnt_r == 2'(QDEPTH));
  assign head_op = ent_r[rp_r];

  // store pushed word
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_op;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### hdl/vid_back.sv
// Execution unit: register stores, enable change scan and result words.
// Depends on vid_pkg and the assertion macro header.
`include "virtual_interrupt_distributor_regs_core_assert.svh"
module vid_back import vid_pkg::*; #(
  parameter int NUM_GUESTS  = 4,
  parameter int IRQ_LINES   = 128,
  parameter int TABLE_WORDS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  vid_op_t     head_op,
  input  logic        empty,
  output logic        pop,
  output logic        clearing,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic [6:0]  out_irq_number,
  output logic [31:0] out_rdata,
  output logic        out_status,
  output logic        out_last
);

  localparam int ENW    = IRQ_LINES / 32;
  localparam int ED     = NUM_GUESTS * ENW;
  localparam int TD     = NUM_GUESTS * TABLE_WORDS;
  localparam int CD     = NUM_GUESTS * CFG_WORDS;
  localparam int EAW    = (ED > 1) ? $clog2(ED) : 1;
  localparam int TAW    = $clog2(TD);
  localparam int CAW    = $clog2(CD);
  localparam int CLR_LEN = (TD > CD) ? ((TD > ED) ? TD : ED) : ((CD > ED) ? CD : ED);
  localparam int CCW    = $clog2(CLR_LEN);
  localparam int GW     = (NUM_GUESTS > 1) ? $clog2(NUM_GUESTS) : 1;

  // stores
  logic [31:0] grp_m [ED];
  logic [31:0] en_m  [ED];
  logic [31:0] pen_m [ED];
  logic [31:0] rep_m [ED];
  logic [31:0] pri_m [TD];
  logic [31:0] tgt_m [TD];
  logic [31:0] cfg_m [CD];
  logic [31:0] ctrl_r [NUM_GUESTS];

  logic [31:0] grp_q, en_q, pen_q, rep_q, pri_q, tgt_q, cfg_q;

  st_t         st_r, st_nxt;
  vid_op_t     cur_r;
  logic [31:0] ch_r, new_r;
  logic [4:0]  bit_r;
  logic        clr_r;
  logic [CCW-1:0] ccnt_r;

  logic [EAW-1:0] ea;
  logic [TAW-1:0] ta;
  logic [CAW-1:0] ca;
  logic [GW-1:0]  gi;

  logic [31:0] lanev, en_new, rd_val, wval;
  logic        we_grp, we_en, we_pen, we_pri, we_tgt, we_cfg, we_ctrl;
  logic        o_ld, o_st, o_last;
  kind_t       o_kind;
  logic [6:0]  o_irq;
  logic [31:0] o_rd;

  logic        strobe_r, status_r, last_r;
  kind_t       kind_r;
  logic [6:0]  irq_r;
  logic [31:0] rdata_r;

  assign clearing = clr_r;
  assign ea = head_op.slot[EAW-1:0];
  assign ta = head_op.slot[TAW-1:0];
  assign ca = head_op.slot[CAW-1:0];
  assign gi = GW'(cur_r.guest);

  assign lanev  = (cur_r.wdata << cur_r.sh) & cur_r.mask;
  assign en_new = cur_r.set ? (en_q | lanev) : (en_q & ~lanev);

  // sweep stores to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= 1'b1;
      ccnt_r <= '0;
    end else if (clr_r) begin
      ccnt_r <= ccnt_r + CCW'(1);
      if (ccnt_r == CCW'(CLR_LEN - 1)) clr_r <= 1'b0;
    end
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (!empty && !clr_r) st_nxt = S_RD;
      S_RD:   st_nxt = (cur_r.op == OP_ENABLE && cur_r.wr) ? S_SCAN : S_IDLE;
      S_SCAN: if (bit_r == 5'd0) st_nxt = S_RESP;
      S_RESP: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // outputs and store write enables
  always_comb begin
    pop     = 1'b0;
    we_grp  = 1'b0;
    we_en   = 1'b0;
    we_pen  = 1'b0;
    we_pri  = 1'b0;
    we_tgt  = 1'b0;
    we_cfg  = 1'b0;
    we_ctrl = 1'b0;
    wval    = cur_r.wdata;
    rd_val  = 32'd0;
    o_ld    = 1'b0;
    o_kind  = KIND_RESP;
    o_irq   = 7'd0;
    o_rd    = 32'd0;
    o_st    = 1'b0;
    o_last  = 1'b1;
    unique case (st_r)
      S_IDLE: begin
        pop = !empty && !clr_r;
      end
      S_RD: begin
        unique case (cur_r.op)
          OP_CTLR: begin
            we_ctrl = cur_r.wr;
            rd_val  = ctrl_r[gi];
          end
          OP_CONST: rd_val = cur_r.wdata;
          OP_GROUP: begin
            we_grp = cur_r.wr;
            rd_val = grp_q;
          end
          OP_ENABLE: begin
            we_en  = cur_r.wr;
            wval   = en_new;
            rd_val = (en_q & cur_r.mask) >> cur_r.sh;
          end
          OP_PEND: begin
            we_pen = cur_r.wr;
            wval   = cur_r.set ? (pen_q | cur_r.wdata) : (pen_q & ~cur_r.wdata);
            rd_val = pen_q;
          end
          OP_PRIO: begin
            we_pri = cur_r.wr;
            rd_val = pri_q;
          end
          OP_TARGET: begin
            we_tgt = cur_r.wr;
            wval   = (tgt_q & ~cur_r.mask) | lanev;
            rd_val = (tgt_q & cur_r.mask) >> cur_r.sh;
          end
          OP_CFG: begin
            we_cfg = cur_r.wr;
            rd_val = cfg_q;
          end
          default: rd_val = 32'd0;
        endcase
        o_ld = !(cur_r.op == OP_ENABLE && cur_r.wr);
        o_st = (cur_r.op == OP_BAD);
        o_rd = (o_st || cur_r.wr) ? 32'd0 : rd_val;
      end
      S_SCAN: begin
        o_ld   = ch_r[bit_r];
        o_kind = new_r[bit_r] ? KIND_EN : KIND_DIS;
        o_irq  = {cur_r.eword[1:0], bit_r};
        o_last = 1'b0;
      end
      S_RESP: begin
        o_ld = 1'b1;
      end
      default: o_ld = 1'b0;
    endcase
  end

  // control state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      strobe_r <= 1'b0;
      for (int k = 0; k < NUM_GUESTS; k++) ctrl_r[k] <= 32'd0;
    end else begin
      st_r     <= st_nxt;
      strobe_r <= o_ld;
      if (we_ctrl) ctrl_r[gi] <= cur_r.wdata;
    end
  end

  // hold current word, scan state and result payload
  always_ff @(posedge clk) begin
    if (pop) cur_r <= head_op;
    if (st_r == S_RD) begin
      ch_r  <= rep_q ^ en_new;
      new_r <= en_new;
      bit_r <= 5'd31;
    end else if (st_r == S_SCAN) begin
      bit_r <= bit_r - 5'd1;
    end
    kind_r   <= o_kind;
    irq_r    <= o_irq;
    rdata_r  <= o_rd;
    status_r <= o_st;
    last_r   <= o_last;
  end

  // enable-width stores
  always_ff @(posedge clk) begin
    if (clr_r) begin
      if (32'(ccnt_r) < ED) begin
        grp_m[ccnt_r[EAW-1:0]] <= 32'd0;
        en_m[ccnt_r[EAW-1:0]]  <= 32'd0;
        pen_m[ccnt_r[EAW-1:0]] <= 32'd0;
        rep_m[ccnt_r[EAW-1:0]] <= 32'd0;
      end
    end else begin
      if (we_grp) grp_m[cur_r.slot[EAW-1:0]] <= wval;
      if (we_en) begin
        en_m[cur_r.slot[EAW-1:0]]  <= wval;
        rep_m[cur_r.slot[EAW-1:0]] <= wval;
      end
      if (we_pen) pen_m[cur_r.slot[EAW-1:0]] <= wval;
    end
    if (pop) begin
      grp_q <= grp_m[ea];
      en_q  <= en_m[ea];
      pen_q <= pen_m[ea];
      rep_q <= rep_m[ea];
    end
  end

  // priority and target tables
  always_ff @(posedge clk) begin
    if (clr_r) begin
      if (32'(ccnt_r) < TD) begin
        pri_m[ccnt_r[TAW-1:0]] <= 32'd0;
        tgt_m[ccnt_r[TAW-1:0]] <= 32'd0;
      end
    end else begin
      if (we_pri) pri_m[cur_r.slot[TAW-1:0]] <= wval;
      if (we_tgt) tgt_m[cur_r.slot[TAW-1:0]] <= wval;
    end
    if (pop) begin
      pri_q <= pri_m[ta];
      tgt_q <= tgt_m[ta];
    end
  end

  // trigger config table
  always_ff @(posedge clk) begin
    if (clr_r) begin
      if (32'(ccnt_r) < CD) cfg_m[ccnt_r[CAW-1:0]] <= 32'd0;
    end else if (we_cfg) begin
      cfg_m[cur_r.slot[CAW-1:0]] <= wval;
    end
    if (pop) cfg_q <= cfg_m[ca];
  end

  assign out_strobe     = strobe_r;
  assign out_kind       = kind_r;
  assign out_irq_number = irq_r;
  assign out_rdata      = rdata_r;
  assign out_status     = status_r;
  assign out_last       = last_r;

  `VID_ASSERT_IMP(a_scan_enw, st_r == S_SCAN, cur_r.op == OP_ENABLE && cur_r.wr, "scan without enable write")
  `VID_ASSERT_IMP(a_no_pop_clr, pop, !clr_r, "queue popped during clearing pass")
  `VID_ASSERT_NXT(a_resp_last, st_r == S_RESP, strobe_r && last_r && kind_r == KIND_RESP, "missing final response")

endmodule

### hdl/virtual_interrupt_distributor_regs_core.sv
// Top level of the per-guest interrupt distributor register file.
// Depends on vid_pkg, vid_front, vid_queue and vid_back.
// Usage:
//   Present an access on in_cmd, in_guest, in_reg_offset, in_wdata and
//   in_access_size with start high; it is taken at the edge where busy is
//   low. busy is high while the two-word queue is full or during the
//   clearing pass after reset.
//   Results appear one per cycle on the out_ ports with out_strobe high for
//   exactly one cycle; the receiver cannot stall them.
//   Every access ends with one response word (out_last high). An enable
//   write first emits one event word per changed enable bit, highest first.
// Sequencing:
//   A plain access is read from the stores, then executed, and its response
//   word is registered; the next access is not begun until it is done.
//   An enable write scans its 32 bits one per cycle, then gives its response.
// Reset:
//   rst_n low clears control state and CTLR words. A clearing pass then
//   zeroes every store entry, one entry a cycle, with busy held high.
module virtual_interrupt_distributor_regs_core import vid_pkg::*; #(
  parameter int NUM_GUESTS  = 4,
  parameter int IRQ_LINES   = 128,
  parameter int TABLE_WORDS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [1:0]  in_guest,
  input  logic [11:0] in_reg_offset,
  input  logic [31:0] in_wdata,
  input  logic [1:0]  in_access_size,
  output logic        out_strobe,
  output logic [1:0]  out_kind,
  output logic [6:0]  out_irq_number,
  output logic [31:0] out_rdata,
  output logic        out_status,
  output logic        out_last
);

  vid_op_t dec_op, head_op;
  logic    q_empty, q_full, pop, clearing, accept;

  // accept when queue has room and stores are ready
  assign busy   = q_full || clearing;
  assign accept = start && !busy;

  vid_front #(
    .NUM_GUESTS(NUM_GUESTS), .IRQ_LINES(IRQ_LINES), .TABLE_WORDS(TABLE_WORDS)
  ) u_front (
    .in_cmd(in_cmd), .in_guest(in_guest), .in_reg_offset(in_reg_offset),
    .in_wdata(in_wdata), .in_access_size(in_access_size), .op_o(dec_op)
  );

  vid_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(accept), .push_op(dec_op), .pop(pop),
    .head_op(head_op), .empty(q_empty), .full(q_full)
  );

  vid_back #(
    .NUM_GUESTS(NUM_GUESTS), .IRQ_LINES(IRQ_LINES), .TABLE_WORDS(TABLE_WORDS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .head_op(head_op), .empty(q_empty), .pop(pop),
    .clearing(clearing), .out_strobe(out_strobe), .out_kind(out_kind),
    .out_irq_number(out_irq_number), .out_rdata(out_rdata),
    .out_status(out_status), .out_last(out_last)
  );

endmodule
